// ----- sv/rstd_pkg.sv -----
// ----------------------------------------------------------------------------
// rstd_pkg
// types and constants shared by the rssi smoother and trend detector
// ----------------------------------------------------------------------------
package rstd_pkg;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_AGE   = 2'd1,
    CELL_SHIFT = 2'd2,
    CELL_PUSH  = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    logic        vld;
    logic [7:0]  val;
    logic [31:0] tms;
  } hist_ent_t;

  typedef struct packed {
    cell_cmd_t   cmd;
    logic [31:0] now;
    logic [15:0] max_age;
    logic [7:0]  val;
  } cell_ctl_t;

  localparam logic [1:0] CFG_MAX_AGE     = 2'd0;
  localparam logic [1:0] CFG_MIN_SPAN    = 2'd1;
  localparam logic [1:0] CFG_TREND_STEP  = 2'd2;
  localparam logic [1:0] CFG_MIN_ENTRIES = 2'd3;

  localparam logic [15:0] RST_MAX_AGE     = 16'd20000;
  localparam logic [15:0] RST_MIN_SPAN    = 16'd1500;
  localparam logic [3:0]  RST_TREND_STEP  = 4'd2;
  localparam logic [4:0]  RST_MIN_ENTRIES = 5'd4;

  localparam logic [2:0] COLOR_EXCELLENT = 3'd0;
  localparam logic [2:0] COLOR_GOOD      = 3'd1;
  localparam logic [2:0] COLOR_FAIR      = 3'd2;
  localparam logic [2:0] COLOR_WEAK      = 3'd3;
  localparam logic [2:0] COLOR_POOR      = 3'd4;
  localparam logic [2:0] COLOR_VERY_WEAK = 3'd5;
  localparam logic [2:0] COLOR_GREY      = 3'd6;

  localparam logic signed [7:0] LVL_EXCELLENT = -8'sd45;
  localparam logic signed [7:0] LVL_GOOD      = -8'sd55;
  localparam logic signed [7:0] LVL_FAIR      = -8'sd65;
  localparam logic signed [7:0] LVL_WEAK      = -8'sd75;
  localparam logic signed [7:0] LVL_POOR      = -8'sd85;
  localparam logic signed [7:0] LVL_DASHES    = -8'sd100;
  localparam logic signed [7:0] LVL_CLAMP_HI  = -8'sd30;
  localparam logic signed [7:0] LVL_CLAMP_LO  = -8'sd90;

  localparam logic [10:0] PERIOD_BASE  = 11'd360;
  localparam logic [10:0] PERIOD_STALE = 11'd1400;
  localparam logic [11:0] PERIOD_HYST  = 12'd100;

  localparam logic [1:0] TREND_FLAT = 2'b00;
  localparam logic [1:0] TREND_UP   = 2'b01;
  localparam logic [1:0] TREND_DOWN = 2'b11;

endpackage

// ----- sv/rstd_in_if.sv -----
// ----------------------------------------------------------------------------
// rstd_in_if
// sample channel: valid/ready handshake with rssi, fresh flag and timestamp
// ----------------------------------------------------------------------------
interface rstd_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] rssi_dbm;
  logic              is_fresh;
  logic [31:0]       now_ms;

  modport source (output valid, output rssi_dbm, output is_fresh, output now_ms,
                  input ready);
  modport sink   (input valid, input rssi_dbm, input is_fresh, input now_ms,
                  output ready);
endinterface

// ----- sv/rstd_out_if.sv -----
// ----------------------------------------------------------------------------
// rstd_out_if
// result channel: valid/ready handshake with display, pulse and trend fields
// ----------------------------------------------------------------------------
interface rstd_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] shown_dbm;
  logic [2:0]        color_class;
  logic              show_dashes;
  logic [10:0]       pulse_ms;
  logic signed [1:0] trend_dir;

  modport source (output valid, output shown_dbm, output color_class,
                  output show_dashes, output pulse_ms, output trend_dir,
                  input ready);
  modport sink   (input valid, input shown_dbm, input color_class,
                  input show_dashes, input pulse_ms, input trend_dir,
                  output ready);
endinterface

// ----- sv/rstd_cell.sv -----
// ----------------------------------------------------------------------------
// rstd_cell
// one history slot: ages itself, shifts down from its upper neighbor across
// holes, or takes the new sample when it is the first free slot
// ----------------------------------------------------------------------------
module rstd_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rstd_pkg::cell_ctl_t  ctl,
  input  rstd_pkg::hist_ent_t  upper,
  input  logic                 lower_vld,
  input  logic                 hole_in,
  output logic                 hole_out,
  output rstd_pkg::hist_ent_t  ent
);

  logic        vld_r, vld_nxt;
  logic [7:0]  val_r, val_nxt;
  logic [31:0] tms_r, tms_nxt;
  logic [31:0] age;
  logic        keep;

  assign age      = ctl.now - tms_r;
  assign keep     = age <= {16'd0, ctl.max_age};
  assign hole_out = hole_in | ~vld_r;

  always_comb begin
    vld_nxt = vld_r;
    val_nxt = val_r;
    tms_nxt = tms_r;
    unique case (ctl.cmd)
      rstd_pkg::CELL_AGE: begin
        vld_nxt = vld_r & keep;
      end
      rstd_pkg::CELL_SHIFT: begin
        if (hole_out) begin
          vld_nxt = upper.vld;
          val_nxt = upper.val;
          tms_nxt = upper.tms;
        end
      end
      rstd_pkg::CELL_PUSH: begin
        if (!vld_r && lower_vld) begin
          vld_nxt = 1'b1;
          val_nxt = ctl.val;
          tms_nxt = ctl.now;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    tms_r <= tms_nxt;
  end

  assign ent.vld = vld_r;
  assign ent.val = val_r;
  assign ent.tms = tms_r;

endmodule

// ----- sv/rssi_smoother_trend_detector_core.sv -----
// ----------------------------------------------------------------------------
// rssi_smoother_trend_detector_core
// smoothed rssi display, color class, pulse period with hysteresis and
// trend over a row of history cells
// ----------------------------------------------------------------------------
// fresh sample: passes through idle, age, compact, push, read, eval and out, with
//   the compaction pass walking holes down the cell row one step per cycle
// stale sample: idle, eval and out; one sample is in flight at a time, the next
//   is accepted once the state machine is back in idle after the result is loaded
// reset: synchronous, history empty, average unseeded, period 1400 ms
// ----------------------------------------------------------------------------
module rssi_smoother_trend_detector_core #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  rstd_in_if.sink      in_ch,
  rstd_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [15:0]  cfg_wdata
);

  localparam int D  = HISTORY_DEPTH;
  localparam int CW = $clog2(D + 1);
  localparam int SW = $clog2(D);
  localparam int MW = (CW > 5) ? CW : 5;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_AGE     = 7'b0000010,
    S_COMPACT = 7'b0000100,
    S_PUSH    = 7'b0001000,
    S_READ    = 7'b0010000,
    S_EVAL    = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [SW-1:0] step_r;

  logic [15:0] max_age_r, min_span_r;
  logic [3:0]  trend_step_r;
  logic [4:0]  min_entries_r;

  logic signed [7:0]  rssi_r;
  logic               fresh_r;
  logic [31:0]        now_r;
  logic signed [11:0] avg_r;
  logic signed [7:0]  shown_r;
  logic [1:0]         trend_r;
  logic [2:0]         color_r;
  logic [10:0]        target_r;
  logic [10:0]        held_r;

  logic              out_valid_r;
  logic signed [7:0] out_shown_r;
  logic [2:0]        out_color_r;
  logic              out_dashes_r;
  logic [10:0]       out_pulse_r;
  logic [1:0]        out_trend_r;

  logic in_go, out_go;

  // history cell row
  rstd_pkg::hist_ent_t ent [D];
  rstd_pkg::hist_ent_t feed;
  rstd_pkg::cell_ctl_t cell_ctl;
  logic [D:0]          hole;
  logic [D:0]          vld_ext;
  logic [D-1:0]        last_v;

  logic [CW-1:0] rd_cnt;
  logic [7:0]    rd_new0, rd_new1, rd_new2;
  logic [31:0]   rd_tnew;
  logic          dup, full;

  assign vld_ext[D] = 1'b0;

  for (genvar g = 0; g < D; g++) begin : g_cell
    rstd_pkg::hist_ent_t up_ent;
    logic                low_vld;

    if (g == D - 1) begin : g_top
      assign up_ent = feed;
    end else begin : g_mid
      assign up_ent = ent[g+1];
    end

    if (g == 0) begin : g_bot
      assign low_vld = 1'b1;
    end else begin : g_low
      assign low_vld = vld_ext[g-1];
    end

    rstd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .upper     (up_ent),
      .lower_vld (low_vld),
      .hole_in   (hole[g]),
      .hole_out  (hole[g+1]),
      .ent       (ent[g])
    );

    assign vld_ext[g] = ent[g].vld;
    assign last_v[g]  = vld_ext[g] & ~vld_ext[g+1];
  end

  // newest entries and fill count from the end-of-row marker
  always_comb begin
    rd_cnt  = '0;
    rd_new0 = '0;
    rd_new1 = '0;
    rd_new2 = '0;
    rd_tnew = '0;
    for (int i = 0; i < D; i++) begin
      if (last_v[i]) begin
        rd_cnt  = rd_cnt | CW'(i + 1);
        rd_new0 = rd_new0 | ent[i].val;
        rd_tnew = rd_tnew | ent[i].tms;
      end
    end
    for (int i = 1; i < D; i++) begin
      if (last_v[i]) rd_new1 = rd_new1 | ent[i-1].val;
    end
    for (int i = 2; i < D; i++) begin
      if (last_v[i]) rd_new2 = rd_new2 | ent[i-2].val;
    end
  end

  assign dup  = (rd_cnt != '0) && (rd_new0 == rssi_r);
  assign full = ent[D-1].vld;

  always_comb begin
    cell_ctl.now     = now_r;
    cell_ctl.max_age = max_age_r;
    cell_ctl.val     = rssi_r;
    cell_ctl.cmd     = rstd_pkg::CELL_HOLD;
    unique case (state_r)
      S_AGE:     cell_ctl.cmd = rstd_pkg::CELL_AGE;
      S_COMPACT: cell_ctl.cmd = rstd_pkg::CELL_SHIFT;
      S_PUSH: begin
        if (dup)       cell_ctl.cmd = rstd_pkg::CELL_HOLD;
        else if (full) cell_ctl.cmd = rstd_pkg::CELL_SHIFT;
        else           cell_ctl.cmd = rstd_pkg::CELL_PUSH;
      end
      default: cell_ctl.cmd = rstd_pkg::CELL_HOLD;
    endcase
  end

  // shift everything down by one when pushing into a full row
  assign hole[0]  = (state_r == S_PUSH) && full && !dup;
  assign feed.vld = (state_r == S_PUSH);
  assign feed.val = rssi_r;
  assign feed.tms = now_r;

  // handshakes
  assign in_go       = in_ch.valid && (state_r == S_IDLE);
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_go      = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_ch.valid) state_nxt = in_ch.is_fresh ? S_AGE : S_EVAL;
      S_AGE:     state_nxt = S_COMPACT;
      S_COMPACT: if (step_r == SW'(D - 1)) state_nxt = S_PUSH;
      S_PUSH:    state_nxt = S_READ;
      S_READ:    state_nxt = S_EVAL;
      S_EVAL:    state_nxt = S_OUT;
      S_OUT:     if (out_go) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_AGE) step_r <= '0;
      else if (state_r == S_COMPACT) step_r <= step_r + SW'(1);
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r     <= rstd_pkg::RST_MAX_AGE;
      min_span_r    <= rstd_pkg::RST_MIN_SPAN;
      trend_step_r  <= rstd_pkg::RST_TREND_STEP;
      min_entries_r <= rstd_pkg::RST_MIN_ENTRIES;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rstd_pkg::CFG_MAX_AGE:     max_age_r     <= cfg_wdata;
        rstd_pkg::CFG_MIN_SPAN:    min_span_r    <= cfg_wdata;
        rstd_pkg::CFG_TREND_STEP:  trend_step_r  <= cfg_wdata[3:0];
        rstd_pkg::CFG_MIN_ENTRIES: min_entries_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (in_go) begin
      rssi_r  <= in_ch.rssi_dbm;
      fresh_r <= in_ch.is_fresh;
      now_r   <= in_ch.now_ms;
    end
  end

  // running average in tenths, halving toward the new sample
  logic signed [11:0] r10;
  logic signed [12:0] avg_sum;
  logic signed [12:0] avg_half;

  assign r10      = (12'(rssi_r) <<< 3) + (12'(rssi_r) <<< 1);
  assign avg_sum  = 13'(avg_r) + 13'(r10) + 13'sd1;
  assign avg_half = (avg_sum + (avg_sum < 0 ? 13'sd1 : 13'sd0)) >>> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
    end else if (state_r == S_AGE) begin
      avg_r <= (avg_r == '0) ? r10 : avg_half[11:0];
    end
  end

  // shown value: average / 10 rounded half away from zero
  logic [11:0] avg_abs;
  logic [10:0] avg_m;
  logic [23:0] avg_prod;
  logic [7:0]  avg_q;

  assign avg_abs  = avg_r[11] ? 12'(-avg_r) : avg_r;
  assign avg_m    = avg_abs[10:0] + 11'd5;
  assign avg_prod = 24'(avg_m) * 24'd6554;
  assign avg_q    = avg_prod[23:16];

  always_ff @(posedge clk) begin
    if (state_r == S_READ) shown_r <= avg_r[11] ? -avg_q : avg_q;
  end

  // trend, color and pulse target
  logic              tr_ok, k3;
  logic [MW-1:0]     cnt_w, min_w;
  logic [31:0]       span;
  logic signed [9:0] old_sum, new_sum;
  logic signed [10:0] tr_diff, tr_th;
  logic [5:0]        th_raw;
  logic [1:0]        trend_c;
  logic [2:0]        color_c;
  logic signed [7:0] s_cl;
  logic signed [7:0] d_s;
  logic [11:0]       d40;
  logic [27:0]       per_prod;
  logic [10:0]       target_c;

  always_comb begin
    cnt_w   = MW'(rd_cnt);
    min_w   = MW'(min_entries_r);
    span    = rd_tnew - ent[0].tms;
    k3      = rd_cnt >= CW'(6);
    tr_ok   = (rd_cnt != '0) && (cnt_w >= min_w) && (span >= {16'd0, min_span_r});
    old_sum = 10'(signed'(ent[0].val));
    new_sum = 10'(signed'(rd_new0));
    if (k3) begin
      old_sum = old_sum + 10'(signed'(ent[1].val)) + 10'(signed'(ent[2].val));
      new_sum = new_sum + 10'(signed'(rd_new1)) + 10'(signed'(rd_new2));
    end
    th_raw  = k3 ? (6'(trend_step_r) + {1'b0, trend_step_r, 1'b0}) : 6'(trend_step_r);
    tr_th   = signed'(11'(th_raw));
    tr_diff = 11'(new_sum) - 11'(old_sum);
    if (!tr_ok)              trend_c = rstd_pkg::TREND_FLAT;
    else if (tr_diff >= tr_th)  trend_c = rstd_pkg::TREND_UP;
    else if (tr_diff <= -tr_th) trend_c = rstd_pkg::TREND_DOWN;
    else                     trend_c = rstd_pkg::TREND_FLAT;

    if (shown_r >= rstd_pkg::LVL_EXCELLENT)  color_c = rstd_pkg::COLOR_EXCELLENT;
    else if (shown_r >= rstd_pkg::LVL_GOOD)  color_c = rstd_pkg::COLOR_GOOD;
    else if (shown_r >= rstd_pkg::LVL_FAIR)  color_c = rstd_pkg::COLOR_FAIR;
    else if (shown_r >= rstd_pkg::LVL_WEAK)  color_c = rstd_pkg::COLOR_WEAK;
    else if (shown_r >= rstd_pkg::LVL_POOR)  color_c = rstd_pkg::COLOR_POOR;
    else                                     color_c = rstd_pkg::COLOR_VERY_WEAK;

    if (shown_r > rstd_pkg::LVL_CLAMP_HI)      s_cl = rstd_pkg::LVL_CLAMP_HI;
    else if (shown_r < rstd_pkg::LVL_CLAMP_LO) s_cl = rstd_pkg::LVL_CLAMP_LO;
    else                                       s_cl = shown_r;
    // (-30 - s) * 800 / 60 = d * 40 / 3
    d_s      = rstd_pkg::LVL_CLAMP_HI - s_cl;
    d40      = {1'b0, d_s[5:0], 5'd0} + {3'd0, d_s[5:0], 3'd0};
    per_prod = 28'(d40) * 28'd43691;
    target_c = rstd_pkg::PERIOD_BASE + per_prod[27:17];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EVAL) begin
      if (fresh_r) begin
        trend_r  <= trend_c;
        color_r  <= color_c;
        target_r <= target_c;
      end else begin
        trend_r  <= rstd_pkg::TREND_FLAT;
        color_r  <= rstd_pkg::COLOR_GREY;
        target_r <= rstd_pkg::PERIOD_STALE;
      end
    end
  end

  // period hysteresis and result register
  logic signed [11:0] hy_diff;
  logic [11:0]        hy_abs;
  logic [10:0]        held_nxt;

  assign hy_diff  = signed'({1'b0, target_r}) - signed'({1'b0, held_r});
  assign hy_abs   = hy_diff[11] ? 12'(-hy_diff) : hy_diff;
  assign held_nxt = (hy_abs >= rstd_pkg::PERIOD_HYST) ? target_r : held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= rstd_pkg::PERIOD_STALE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && out_go) begin
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_go) begin
      out_shown_r  <= fresh_r ? shown_r : rssi_r;
      out_color_r  <= color_r;
      out_dashes_r <= !fresh_r && (rssi_r <= rstd_pkg::LVL_DASHES);
      out_pulse_r  <= held_nxt;
      out_trend_r  <= trend_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.shown_dbm   = out_shown_r;
  assign out_ch.color_class = out_color_r;
  assign out_ch.show_dashes = out_dashes_r;
  assign out_ch.pulse_ms    = out_pulse_r;
  assign out_ch.trend_dir   = out_trend_r;

endmodule

// ----- sim/rstd_readout_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rstd_readout_checker
// watches the sample, readout and register ports of the rssi smoother, keeps
// its own smoothed average, history and held pulse period, and compares every
// readout beat field by field with the oldest predicted readout
// ----------------------------------------------------------------------------
module rstd_readout_checker
  import rstd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rstd_in_if          in_ch,
  rstd_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  output int          mismatch_cnt,
  output int          readouts_seen,
  output int          readouts_owed
);

  localparam int DEPTH       = 16;
  localparam int PERIOD_SPAN = 800;
  localparam int LEVEL_RANGE = 60;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic signed [7:0] shown;
    logic [2:0]        color;
    logic              dashes;
    logic [10:0]       pulse;
    logic [1:0]        trend;
  } readout_t;

  int                avg_tenths;
  logic signed [7:0] hist_val [DEPTH];
  logic [31:0]       hist_tms [DEPTH];
  int                hist_cnt;
  int                held_ms;
  logic [15:0]       max_age;
  logic [15:0]       min_span;
  logic [3:0]        step_db;
  logic [4:0]        min_ent;
  readout_t          readout_q [$];

  initial begin
    mismatch_cnt  = 0;
    readouts_seen = 0;
    readouts_owed = 0;
  end

  task automatic smooth_sample(input logic signed [7:0] rssi, input logic fresh,
                               input logic [31:0] now, output readout_t r);
    int          rs, shown, s, target, diff, w, n, k, i, old_sum, new_sum, th, d;
    logic [31:0] age, span;
    logic [2:0]  color;
    logic        dashes;
    logic [1:0]  trend;
    rs     = rssi;
    shown  = rs;
    color  = COLOR_GREY;
    dashes = 1'b0;
    target = int'(PERIOD_STALE);
    trend  = TREND_FLAT;
    if (fresh) begin
      if (avg_tenths == 0) avg_tenths = rs * 10;
      else avg_tenths = (avg_tenths + rs * 10 + 1) / 2;
      shown = (avg_tenths + ((avg_tenths >= 0) ? 5 : -5)) / 10;
      // drop aged entries, keep order
      w = 0;
      for (i = 0; i < hist_cnt; i++) begin
        age = now - hist_tms[i];
        if (age <= {16'd0, max_age}) begin
          hist_val[w] = hist_val[i];
          hist_tms[w] = hist_tms[i];
          w++;
        end
      end
      hist_cnt = w;
      if (w == 0 || hist_val[w-1] != rssi) begin
        if (w >= DEPTH) begin
          for (i = 0; i < DEPTH - 1; i++) begin
            hist_val[i] = hist_val[i+1];
            hist_tms[i] = hist_tms[i+1];
          end
          w = DEPTH - 1;
        end
        hist_val[w] = rssi;
        hist_tms[w] = now;
        hist_cnt    = w + 1;
      end
      if (shown >= LVL_EXCELLENT) color = COLOR_EXCELLENT;
      else if (shown >= LVL_GOOD) color = COLOR_GOOD;
      else if (shown >= LVL_FAIR) color = COLOR_FAIR;
      else if (shown >= LVL_WEAK) color = COLOR_WEAK;
      else if (shown >= LVL_POOR) color = COLOR_POOR;
      else color = COLOR_VERY_WEAK;
      s = shown;
      if (s > LVL_CLAMP_HI) s = LVL_CLAMP_HI;
      if (s < LVL_CLAMP_LO) s = LVL_CLAMP_LO;
      target = int'(PERIOD_BASE) + ((int'(LVL_CLAMP_HI) - s) * PERIOD_SPAN) / LEVEL_RANGE;
      n = hist_cnt;
      if (n != 0 && n >= int'(min_ent)) begin
        span = hist_tms[n-1] - hist_tms[0];
        if (span >= {16'd0, min_span}) begin
          k = (n >= 6) ? 3 : 1;
          old_sum = 0;
          new_sum = 0;
          for (i = 0; i < k; i++) begin
            old_sum += hist_val[i];
            new_sum += hist_val[n-1-i];
          end
          th = int'(step_db) * k;
          d  = new_sum - old_sum;
          if (d >= th) trend = TREND_UP;
          else if (d <= -th) trend = TREND_DOWN;
        end
      end
    end else if (rs <= LVL_DASHES) begin
      dashes = 1'b1;
    end
    diff = target - held_ms;
    if (diff < 0) diff = -diff;
    if (held_ms == 0 || diff >= int'(PERIOD_HYST)) held_ms = target;
    r.shown  = shown[7:0];
    r.color  = color;
    r.dashes = dashes;
    r.pulse  = held_ms[10:0];
    r.trend  = trend;
  endtask

  always @(posedge clk) begin
    readout_t want;
    if (!rst_n) begin
      avg_tenths = 0;
      hist_cnt   = 0;
      held_ms    = int'(PERIOD_STALE);
      max_age    = RST_MAX_AGE;
      min_span   = RST_MIN_SPAN;
      step_db    = RST_TREND_STEP;
      min_ent    = RST_MIN_ENTRIES;
      readout_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MAX_AGE:     max_age  = cfg_wdata;
          CFG_MIN_SPAN:    min_span = cfg_wdata;
          CFG_TREND_STEP:  step_db  = cfg_wdata[3:0];
          CFG_MIN_ENTRIES: min_ent  = cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        smooth_sample(in_ch.rssi_dbm, in_ch.is_fresh, in_ch.now_ms, want);
        readout_q.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        readouts_seen++;
        if (readout_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("%0t: readout beat with no sample pending: shown %0d class %0d",
                     $realtime, out_ch.shown_dbm, out_ch.color_class);
        end else begin
          want = readout_q.pop_front();
          if (out_ch.shown_dbm !== want.shown || out_ch.color_class !== want.color ||
              out_ch.show_dashes !== want.dashes || out_ch.pulse_ms !== want.pulse ||
              out_ch.trend_dir !== want.trend) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX) begin
              $display("%0t: readout %0d exp shown %0d cls %0d dash %0b pulse %0d trend %b",
                       $realtime, readouts_seen, want.shown, want.color, want.dashes,
                       want.pulse, want.trend);
              $display("%0t: readout %0d got shown %0d cls %0d dash %0b pulse %0d trend %b",
                       $realtime, readouts_seen, out_ch.shown_dbm, out_ch.color_class,
                       out_ch.show_dashes, out_ch.pulse_ms, out_ch.trend_dir);
            end
          end
        end
      end
    end
    readouts_owed = readout_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives rssi samples into the smoother and trend detector through a sequence
// of register settings, with random idle bursts on both channels and two long
// readout hold-offs, and reports the verdict of the readout checker
// ----------------------------------------------------------------------------
module testbench;
  import rstd_pkg::*;

  localparam int LIMIT_CYCLES   = 100000;
  localparam int HOLD_CYCLES    = 250;
  localparam int SETTLE_CYCLES  = 40;
  localparam int ITEMS_PER_PASS = 75;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_wdata;
  logic        idle_on;
  logic        hold_req;
  int          cycle_cnt;
  int          fresh_sent;
  int          stale_sent;
  int          settings_used;
  int          mismatch_cnt;
  int          readouts_seen;
  int          readouts_owed;
  logic [31:0] clock_ms;
  int          level;
  int          drift;

  rstd_in_if  in_if ();
  rstd_out_if out_if ();

  rssi_smoother_trend_detector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  rstd_readout_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_if),
    .out_ch        (out_if),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .mismatch_cnt  (mismatch_cnt),
    .readouts_seen (readouts_seen),
    .readouts_owed (readouts_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // readout side: short random stalls, or one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  task automatic send_sample(input int rssi, input logic fresh, input logic [31:0] now);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_if.valid    = 1'b1;
    in_if.rssi_dbm = rssi[7:0];
    in_if.is_fresh = fresh;
    in_if.now_ms   = now;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (fresh) fresh_sent++;
    else stale_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_if.valid = 1'b0;
    wait (readouts_owed == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_registers(input logic [15:0] age, input logic [15:0] span,
                               input logic [15:0] step, input logic [15:0] entries);
    settle();
    write_reg(CFG_MAX_AGE, age);
    write_reg(CFG_MIN_SPAN, span);
    write_reg(CFG_TREND_STEP, step);
    write_reg(CFG_MIN_ENTRIES, entries);
    settings_used++;
  endtask

  // mostly a drifting level on a steady tick, with jumps, wraps and noise
  task automatic random_sample();
    int t_pick, v_pick;
    t_pick = $urandom_range(0, 99);
    v_pick = $urandom_range(0, 99);
    if (t_pick < 3) clock_ms = $urandom;
    else if (t_pick < 6) clock_ms += $urandom_range(1000, 70000);
    else if (t_pick < 8) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 1500);
    else if (t_pick < 12) clock_ms = clock_ms;
    else clock_ms += $urandom_range(50, 250);
    if ($urandom_range(0, 9) == 0) drift = $urandom_range(0, 2) - 1;
    if (v_pick < 6) begin
      level = $urandom_range(0, 255);
      if (level > 127) level -= 256;
    end else if (v_pick >= 10) begin
      level += drift * $urandom_range(0, 3) + $urandom_range(0, 2) - 1;
      if (level > 127) level = 127;
      if (level < -128) level = -128;
    end
    send_sample(level, $urandom_range(0, 99) < 85, clock_ms);
  endtask

  task automatic random_pass(input int hold_at);
    for (int i = 0; i < ITEMS_PER_PASS; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      random_sample();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_MAX_AGE;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.rssi_dbm = '0;
    in_if.is_fresh = 1'b0;
    in_if.now_ms   = '0;
    idle_on        = 1'b1;
    hold_req       = 1'b0;
    fresh_sent     = 0;
    stale_sent     = 0;
    settings_used  = 1;
    clock_ms       = 32'd5000;
    level          = -60;
    drift          = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // stale readings: dashes at and below the floor, grey class
    send_sample(-100, 1'b0, 32'd100);
    send_sample(-99, 1'b0, 32'd200);
    send_sample(-128, 1'b0, 32'd300);
    send_sample(127, 1'b0, 32'd400);
    // seed, average back to zero, reseed, repeated reading
    send_sample(-60, 1'b1, 32'd1000);
    send_sample(60, 1'b1, 32'd1150);
    send_sample(-30, 1'b1, 32'd1300);
    send_sample(-30, 1'b1, 32'd1450);
    send_sample(127, 1'b1, 32'd1600);
    send_sample(-128, 1'b1, 32'd1750);
    // steady climb to fill the history and show a rising trend
    for (int i = 0; i < 12; i++) send_sample(-90 + 4 * i, 1'b1, 32'd2000 + 200 * i);
    // timestamp wrap
    send_sample(-70, 1'b1, 32'hFFFF_FF00);
    send_sample(-75, 1'b1, 32'h0000_0050);

    set_registers(16'd20000, 16'd1500, 16'd2, 16'd4);
    random_pass(-1);
    set_registers(16'd65535, 16'd0, 16'd0, 16'd1);
    random_pass(20);
    set_registers(16'd0, 16'd65535, 16'd15, 16'd31);
    random_pass(-1);
    set_registers(16'd5000, 16'd300, 16'd1, 16'd0);
    random_pass(-1);
    set_registers(16'd30000, 16'd1000, 16'd3, 16'd16);
    random_pass(40);
    set_registers(16'd3000, 16'd600, 16'd2, 16'd17);
    idle_on = 1'b0;
    random_pass(-1);

    settle();
    $display("sent %0d fresh and %0d stale samples under %0d register settings",
             fresh_sent, stale_sent, settings_used);
    $display("checked %0d readouts, %0d mismatches", readouts_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && readouts_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
